[hw/rtl/salt_pepper_neighbor_mean_filter_top_assert.svh]
// assertion macros for the filter's checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef SALT_PEPPER_NEIGHBOR_MEAN_FILTER_TOP_ASSERT_SVH
`define SALT_PEPPER_NEIGHBOR_MEAN_FILTER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is held
`define SPNMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SPNMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checked at every edge, reset included
`define SPNMF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

[hw/rtl/spnmf_pkg.sv]
// types and constants of the salt-and-pepper neighbor-mean filter
// no dependencies
package spnmf_pkg;

    localparam int CFG_W     = 12;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 11;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 12'd2048;

    typedef logic [PIX_W-1:0] pix_t;

    localparam pix_t PIX_BLACK = 8'd0;
    localparam pix_t PIX_WHITE = 8'd255;

    typedef enum logic
    {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic mask_up;
        logic mask_mid;
        logic col_start;
        logic emit;
        logic result;
        logic frame_end;
    } step_ctl_t;

    typedef struct packed
    {
        logic frame_end;
        logic was_replaced;
        pix_t pixel;
    } out_item_t;

endpackage

[hw/rtl/salt_pepper_neighbor_mean_filter_top.sv]
// 3x3 salt-and-pepper filter: 0 or 255 replaced by the mean of its eight neighbors
// throughput one request per cycle while s_axis_tready is high; a height-1 frame ends with a silent zero step
// a request's result is registered in the window stage, the mean stage and the output queue before m_axis_tvalid
// line buffers are two 1R1W rams with a registered read, read-modify-write over 2 stages
// rst_n is asynchronous: counters, window and output queue clear; rams keep old data
module salt_pepper_neighbor_mean_filter_top
    import spnmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_we,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  pix_t             s_axis_tdata,   // pixel_in
    input  logic             s_axis_tuser,   // kind

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output pix_t             m_axis_tdata,   // pixel_out
    output logic             m_axis_tuser,   // was_replaced
    output logic             m_axis_tlast    // frame_end
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 3);
    localparam int PEND_W  = $clog2(MAX_WIDTH + 2);
    localparam int WCMP_W  = ((CFG_W > W_W) ? CFG_W : W_W) + 1;
    localparam int HCMP_W  = ((CFG_W > H_W) ? CFG_W : H_W) + 1;

    // configuration
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [WCMP_W-1:0] width_wide;
    logic [HCMP_W-1:0] height_wide;
    logic [W_W-1:0]    w_eff;
    logic [H_W-1:0]    h_eff;

    // issue stage
    logic [COL_W-1:0]  col_reg, col_next, col_eff;
    logic [ROW_W-1:0]  row_reg, row_next, row_inc;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              silent_reg, silent_next;
    logic [W_W-1:0]    col_inc;
    logic              col_wrap;
    logic              pend_nz;
    logic              in_fire;
    logic              drain;
    logic              pixel;
    logic              step;
    step_ctl_t         ctl;
    pix_t              step_pix;
    logic              fwd_next;

    // line buffers
    pix_t              upper_mem  [MAX_WIDTH];
    pix_t              middle_mem [MAX_WIDTH];
    pix_t              up_rd_reg;
    pix_t              mid_rd_reg;

    // window stage
    logic              s1_step_reg;
    step_ctl_t         s1_ctl_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    pix_t              s1_pix_reg;
    logic              s1_fwd_reg;
    pix_t              fwd_up_reg;
    pix_t              fwd_mid_reg;
    pix_t              up_raw;
    pix_t              mid_raw;
    pix_t              col2     [3];
    pix_t              win_c1_reg [3];
    pix_t              win_c2_reg [3];
    logic              s1_res;

    // mean stage
    pix_t              emit_win_reg [3][3];
    logic              s2_res_reg;
    logic              s2_emit_reg;
    logic              s2_fe_reg;
    logic [SUM_W-1:0]  nb_sum;
    logic              noise;
    out_item_t         res_item;

    // output queue
    out_item_t         out_buf [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OUT_CNT_W-1:0] credit;
    logic              push;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_SIZE_RESET;
            height_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // clamp sizes to 1..max
    assign width_wide  = WCMP_W'(width_reg);
    assign height_wide = HCMP_W'(height_reg);

    always_comb
    begin
        priority if (width_wide == '0)
            w_eff = W_W'(1);
        else if (width_wide > WCMP_W'(MAX_WIDTH))
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = W_W'(width_wide);

        priority if (height_wide == '0)
            h_eff = H_W'(1);
        else if (height_wide > HCMP_W'(MAX_HEIGHT))
            h_eff = H_W'(MAX_HEIGHT);
        else
            h_eff = H_W'(height_wide);
    end

    // ---------------- issue: counters, ram read ----------------
    assign credit = cnt_reg + OUT_CNT_W'(s1_res) + OUT_CNT_W'(s2_res_reg);
    assign s_axis_tready = !silent_reg && (credit < OUT_CNT_W'(OUT_DEPTH));

    always_comb
    begin
        col_eff  = (W_W'(col_reg) >= w_eff) ? '0 : col_reg;
        col_inc  = W_W'(col_eff) + W_W'(1);
        col_wrap = col_inc >= w_eff;
        row_inc  = (row_reg == '1) ? row_reg : row_reg + ROW_W'(1);
        pend_nz  = pend_reg != '0;
        in_fire  = s_axis_tvalid && s_axis_tready;
        drain    = in_fire && pend_nz;
        pixel    = in_fire && !pend_nz && (s_axis_tuser == KIND_PIXEL);
        step     = silent_reg || drain || pixel;

        ctl.mask_up   = row_reg >= ROW_W'(2);
        ctl.mask_mid  = row_reg != '0;
        ctl.col_start = col_eff == '0;
        ctl.emit      = ctl.col_start ? ctl.mask_up : ctl.mask_mid;
        ctl.result    = drain || (pixel && ctl.emit);
        ctl.frame_end = drain && (pend_reg == PEND_W'(1));
        step_pix      = pixel ? s_axis_tdata : '0;

        col_next    = col_reg;
        row_next    = row_reg;
        pend_next   = pend_reg;
        silent_next = 1'b0;

        if (step)
        begin
            col_next = col_wrap ? '0 : COL_W'(col_inc);
            row_next = col_wrap ? row_inc : row_reg;
        end

        if (drain)
        begin
            pend_next = pend_reg - PEND_W'(1);
            if (pend_reg == PEND_W'(1))
            begin
                col_next = '0;
                row_next = '0;
            end
        end

        // frame done: owe width+1 outputs, or width plus a zero step for one-row frames
        if (pixel && (row_next >= ROW_W'(h_eff)))
        begin
            if (row_next == ROW_W'(1))
            begin
                pend_next   = PEND_W'(w_eff);
                silent_next = 1'b1;
            end
            else
            begin
                pend_next = PEND_W'(w_eff) + PEND_W'(1);
            end
        end

        // read during the write of the same entry: take the data being written
        fwd_next = step && s1_step_reg && (s1_addr_reg == col_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            silent_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            pend_reg   <= pend_next;
            silent_reg <= silent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_step_reg)
        begin
            upper_mem[s1_addr_reg]  <= mid_raw;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
        if (step)
        begin
            up_rd_reg  <= upper_mem[col_eff];
            mid_rd_reg <= middle_mem[col_eff];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_step_reg <= 1'b0;
            s1_ctl_reg  <= '0;
            s1_fwd_reg  <= 1'b0;
        end
        else
        begin
            s1_step_reg <= step;
            s1_ctl_reg  <= ctl;
            s1_fwd_reg  <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= col_eff;
        s1_pix_reg  <= step_pix;
        fwd_up_reg  <= mid_raw;
        fwd_mid_reg <= s1_pix_reg;
    end

    // ---------------- window: shift in the new column ----------------
    assign s1_res = s1_step_reg && s1_ctl_reg.result;

    always_comb
    begin
        up_raw  = s1_fwd_reg ? fwd_up_reg : up_rd_reg;
        mid_raw = s1_fwd_reg ? fwd_mid_reg : mid_rd_reg;
        col2[0] = s1_ctl_reg.mask_up ? up_raw : '0;
        col2[1] = s1_ctl_reg.mask_mid ? mid_raw : '0;
        col2[2] = s1_pix_reg;
    end

    // only the left and middle columns are kept; the right one is the new column, the left one the old middle column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_c1_reg[k] <= '0;
                win_c2_reg[k] <= '0;
            end
        end
        else if (s1_step_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_c1_reg[k] <= s1_ctl_reg.col_start ? '0 : win_c2_reg[k];
                win_c2_reg[k] <= col2[k];
            end
        end
    end

    // at a row start the centre leaves with an empty right column
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            emit_win_reg[k][0] <= win_c1_reg[k];
            emit_win_reg[k][1] <= win_c2_reg[k];
            emit_win_reg[k][2] <= s1_ctl_reg.col_start ? '0 : col2[k];
        end
        s2_emit_reg <= s1_ctl_reg.emit;
        s2_fe_reg   <= s1_ctl_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_res_reg <= 1'b0;
        else
            s2_res_reg <= s1_res;
    end

    // ---------------- mean and replace ----------------
    always_comb
    begin
        nb_sum = SUM_W'(emit_win_reg[0][0]) + SUM_W'(emit_win_reg[0][1])
               + SUM_W'(emit_win_reg[0][2]) + SUM_W'(emit_win_reg[1][0])
               + SUM_W'(emit_win_reg[1][2]) + SUM_W'(emit_win_reg[2][0])
               + SUM_W'(emit_win_reg[2][1]) + SUM_W'(emit_win_reg[2][2]);
        noise  = (emit_win_reg[1][1] == PIX_BLACK) || (emit_win_reg[1][1] == PIX_WHITE);

        res_item.frame_end    = s2_fe_reg;
        res_item.was_replaced = s2_emit_reg && noise;
        if (!s2_emit_reg)
            res_item.pixel = '0;
        else if (noise)
            res_item.pixel = nb_sum[SUM_W-1:3];
        else
            res_item.pixel = emit_win_reg[1][1];
    end

    // ---------------- output queue ----------------
    assign push = s2_res_reg;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + OUT_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - OUT_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            out_buf[wr_ptr_reg] <= res_item;
    end

    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = out_buf[rd_ptr_reg].pixel;
    assign m_axis_tuser  = out_buf[rd_ptr_reg].was_replaced;
    assign m_axis_tlast  = out_buf[rd_ptr_reg].frame_end;

endmodule

[hw/rtl/spnmf_checker.sv]
// port-level checks of the salt-and-pepper filter, bound to its top level
// depends on spnmf_pkg and salt_pepper_neighbor_mean_filter_top_assert.svh
`include "salt_pepper_neighbor_mean_filter_top_assert.svh"

module spnmf_checker
    import spnmf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input pix_t m_axis_tdata,   // pixel_out
    input logic m_axis_tuser,   // was_replaced
    input logic m_axis_tlast    // frame_end
);

    // a stalled result holds
    `SPNMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}), "result changed while stalled")

    // an empty output queue fills only from a request that has passed the window and mean stages
    `SPNMF_ASSERT_SAME(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 3), "result without a matching request")

    // nothing is offered while reset is held
    `SPNMF_ASSERT_ALWAYS(a_reset_quiet, rst_n || !m_axis_tvalid, "result offered during reset")

endmodule

bind salt_pepper_neighbor_mean_filter_top spnmf_checker u_spnmf_checker (.*);
